>>> hdl/lsr_pkg.sv
// Shared types, constants and helpers for the literal string replacer.
// No dependencies; every other file of the block refers to it by scoped names.
package lsr_pkg;

  // Default bounds for the pattern window and the replacement burst.
  localparam int MaxPatternDef     = 16;
  localparam int MaxReplacementDef = 16;

  // Bytes that the pattern and replacement registers can hold.
  localparam int RegBytes = 16;

  // Command queue between the front and back parts.
  localparam int FifoDepth = 4;

  // Configuration port geometry: 64-bit registers at 8-byte strides.
  localparam int AddrWidth = 6;
  localparam int DataWidth = 64;
  localparam int IdxWidth  = 3;

  // Register indexes.
  localparam logic [IdxWidth-1:0] RegPatternLow      = 3'd0;
  localparam logic [IdxWidth-1:0] RegPatternHigh     = 3'd1;
  localparam logic [IdxWidth-1:0] RegPatternLength   = 3'd2;
  localparam logic [IdxWidth-1:0] RegReplacementLow  = 3'd3;
  localparam logic [IdxWidth-1:0] RegReplacementHigh = 3'd4;
  localparam logic [IdxWidth-1:0] RegReplacementLen  = 3'd5;
  localparam logic [IdxWidth-1:0] RegIgnoreCase      = 3'd6;
  localparam logic [IdxWidth-1:0] RegReplaceAll      = 3'd7;

  // Work the back part does for one queued command.
  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,  // one byte
    OP_REPL = 2'd1,  // the whole replacement
    OP_MARK = 2'd2   // bare end marker
  } lsr_op_e;

  typedef struct packed {
    lsr_op_e     op;
    logic [7:0]  data;
    logic        eos;
  } lsr_cmd_t;

  typedef struct packed {
    logic [127:0] pattern;       // byte 0 in the low bits
    logic [4:0]   pattern_length;
    logic [127:0] replacement;   // byte 0 in the low bits
    logic [4:0]   replacement_length;
    logic         ignore_case;
    logic         replace_all;
    logic         clear_window;  // pulse: pattern_length is being written
  } lsr_cfg_t;

  // Byte idx of a register pair; bytes past the registers read as zero.
  function automatic logic [7:0] pick_byte(input logic [127:0] bytes,
                                           input int unsigned idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx < RegBytes) begin
      b = bytes[idx*8 +: 8];
    end
    return b;
  endfunction

  // ASCII lower-casing when folding is on.
  function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
    logic [7:0] r;
    r = c;
    if (ic && (c inside {[8'h41:8'h5A]})) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

>>> hdl/literal_string_replace.sv
// Top level of the streaming literal find-and-replace block.
// Depends on lsr_pkg, lsr_regs, lsr_front, lsr_fifo and lsr_back.
//
// Usage:
//   Input channel: present data_byte_i and last_byte_i with push; a transfer
//   happens at a clock edge where push is high and full is low. last_byte_i
//   marks the final byte of a string.
//   Output channel: while empty is low the oldest result is on out_byte_o,
//   byte_valid_o and end_of_string_o; a transfer happens when pop is high.
//   Configuration: APB-style port, 64-bit registers at byte address 8*i;
//   pready is always high. Write only while the block is idle. Writing
//   pattern_length discards any pending window bytes.
// Timing:
//   The front takes one byte per cycle while full is low. The back gives one
//   byte per cycle while commands wait and the receiver pops, so a matched
//   pattern of P bytes replaced by R bytes yields R output bytes. A final
//   byte holds full high while the bytes that remain in the window (at most
//   MAX_PATTERN-1) drain. A byte released by an input transfer passes through
//   the command queue and then the output register before it shows at the output.
//   A four-entry command queue between front and back absorbs bursts; when
//   the receiver stalls, the output register holds and the queue fills, then
//   full rises. Reset empties the window, queue and output register and
//   loads the register defaults.
module literal_string_replace #(
  parameter int MAX_PATTERN     = lsr_pkg::MaxPatternDef,
  parameter int MAX_REPLACEMENT = lsr_pkg::MaxReplacementDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lsr_pkg::AddrWidth-1:0]  paddr,
  input  logic [lsr_pkg::DataWidth-1:0]  pwdata,
  output logic [lsr_pkg::DataWidth-1:0]  prdata,
  output logic                           pready,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     data_byte_i,
  input  logic                           last_byte_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     out_byte_o,
  output logic                           byte_valid_o,
  output logic                           end_of_string_o
);

  lsr_pkg::lsr_cfg_t cfg;
  lsr_pkg::lsr_cmd_t wr_cmd, rd_cmd;
  logic              cmd_push, cmd_full, cmd_valid, cmd_pop;

  // Hold the settings; flag writes to pattern_length for the window.
  lsr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Match incoming bytes against the pattern and issue commands.
  lsr_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .cmd_o       (wr_cmd),
    .cmd_push_o  (cmd_push),
    .cmd_full_i  (cmd_full)
  );

  // Buffer commands so either side can stall on its own.
  lsr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_push),
    .wdata_i (wr_cmd),
    .full_o  (cmd_full),
    .rd_i    (cmd_pop),
    .rdata_o (rd_cmd),
    .valid_o (cmd_valid)
  );

  // Expand commands into output transfers.
  lsr_back #(
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (rd_cmd),
    .cmd_valid_i     (cmd_valid),
    .cmd_pop_o       (cmd_pop),
    .empty           (empty),
    .pop             (pop),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .end_of_string_o (end_of_string_o)
  );

  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !byte_valid_o) |-> (end_of_string_o && (out_byte_o == 8'h00)))
    else $error("bare result is not a clean end marker");

endmodule

>>> hdl/lsr_regs.sv
// Configuration register file with an APB-style slave port.
// Depends on lsr_pkg for register indexes and the configuration struct.
module lsr_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lsr_pkg::AddrWidth-1:0]   paddr,
  input  logic [lsr_pkg::DataWidth-1:0]   pwdata,
  output logic [lsr_pkg::DataWidth-1:0]   prdata,
  output logic                            pready,
  output lsr_pkg::lsr_cfg_t               cfg_o
);

  logic [63:0] pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
  logic [4:0]  pat_len_q, rep_len_q;
  logic        ic_q, all_q;
  logic        wr;
  logic [lsr_pkg::IdxWidth-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[lsr_pkg::AddrWidth-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= 5'd1;
      rep_lo_q  <= '0;
      rep_hi_q  <= '0;
      rep_len_q <= '0;
      ic_q      <= 1'b0;
      all_q     <= 1'b0;
    end else if (wr) begin
      case (idx)
        lsr_pkg::RegPatternLow:      pat_lo_q  <= pwdata;
        lsr_pkg::RegPatternHigh:     pat_hi_q  <= pwdata;
        lsr_pkg::RegPatternLength:   pat_len_q <= pwdata[4:0];
        lsr_pkg::RegReplacementLow:  rep_lo_q  <= pwdata;
        lsr_pkg::RegReplacementHigh: rep_hi_q  <= pwdata;
        lsr_pkg::RegReplacementLen:  rep_len_q <= pwdata[4:0];
        lsr_pkg::RegIgnoreCase:      ic_q      <= pwdata[0];
        lsr_pkg::RegReplaceAll:      all_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lsr_pkg::RegPatternLow:      prdata = pat_lo_q;
      lsr_pkg::RegPatternHigh:     prdata = pat_hi_q;
      lsr_pkg::RegPatternLength:   prdata = {59'd0, pat_len_q};
      lsr_pkg::RegReplacementLow:  prdata = rep_lo_q;
      lsr_pkg::RegReplacementHigh: prdata = rep_hi_q;
      lsr_pkg::RegReplacementLen:  prdata = {59'd0, rep_len_q};
      lsr_pkg::RegIgnoreCase:      prdata = {63'd0, ic_q};
      lsr_pkg::RegReplaceAll:      prdata = {63'd0, all_q};
      default:                     prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.pattern            = {pat_hi_q, pat_lo_q};
    cfg_o.pattern_length     = pat_len_q;
    cfg_o.replacement        = {rep_hi_q, rep_lo_q};
    cfg_o.replacement_length = rep_len_q;
    cfg_o.ignore_case        = ic_q;
    cfg_o.replace_all        = all_q;
    cfg_o.clear_window       = wr && (idx == lsr_pkg::RegPatternLength);
  end

endmodule

>>> hdl/lsr_front.sv
// Front part: sliding window, parallel pattern compare, command issue and flush.
// Depends on lsr_pkg for the command and configuration types.
module lsr_front #(
  parameter int MAX_PATTERN = lsr_pkg::MaxPatternDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsr_pkg::lsr_cfg_t  cfg_i,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output lsr_pkg::lsr_cmd_t  cmd_o,
  output logic               cmd_push_o,
  input  logic               cmd_full_i
);

  localparam int FW = $clog2(MAX_PATTERN + 1);

  logic [7:0]    win_q [MAX_PATTERN];
  logic [7:0]    win_d [MAX_PATTERN];
  logic [7:0]    app   [MAX_PATTERN];  // window with the new byte appended
  logic [7:0]    app_sh[MAX_PATTERN];  // appended window, oldest dropped
  logic [7:0]    win_sh[MAX_PATTERN];  // stored window, oldest dropped
  logic [FW-1:0] fill_q, fill_d;
  logic          first_q, first_d;
  logic          flush_q, flush_d;
  logic [FW-1:0] plen;
  logic          accept, do_cmp, hit, all_ok;
  logic          main_vld;
  logic [FW-1:0] new_fill;
  lsr_pkg::lsr_cmd_t main_cmd;

  // Effective pattern length: zero acts as one, saturate at the window depth.
  always_comb begin
    if (cfg_i.pattern_length == 5'd0) begin
      plen = FW'(1);
    end else if (int'(cfg_i.pattern_length) > MAX_PATTERN) begin
      plen = FW'(MAX_PATTERN);
    end else begin
      plen = FW'(cfg_i.pattern_length);
    end
  end

  assign full   = flush_q || cmd_full_i;
  assign accept = push && !full;
  assign do_cmp = (fill_q == plen - FW'(1));

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      app[j] = (fill_q == FW'(j)) ? data_byte_i : win_q[j];
    end
    for (int j = 0; j < MAX_PATTERN - 1; j++) begin
      app_sh[j] = app[j+1];
      win_sh[j] = win_q[j+1];
    end
    app_sh[MAX_PATTERN-1] = 8'h00;
    win_sh[MAX_PATTERN-1] = 8'h00;
  end

  // One comparator per window lane; lanes past the pattern always agree.
  always_comb begin
    all_ok = 1'b1;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (j < int'(plen)) begin
        if (lsr_pkg::fold(app[j], cfg_i.ignore_case) !=
            lsr_pkg::fold(lsr_pkg::pick_byte(cfg_i.pattern, j), cfg_i.ignore_case)) begin
          all_ok = 1'b0;
        end
      end
    end
  end

  assign hit = do_cmp && (cfg_i.replace_all || !first_q) && all_ok;

  always_comb begin
    win_d      = win_q;
    fill_d     = fill_q;
    first_d    = first_q;
    flush_d    = flush_q;
    cmd_push_o = 1'b0;
    cmd_o      = '{op: lsr_pkg::OP_BYTE, data: 8'h00, eos: 1'b0};
    main_vld   = 1'b0;
    main_cmd   = '{op: lsr_pkg::OP_BYTE, data: 8'h00, eos: 1'b0};
    new_fill   = fill_q;

    if (flush_q) begin
      // Drain the window one byte per transfer.
      if (!cmd_full_i) begin
        cmd_push_o = 1'b1;
        cmd_o      = '{op: lsr_pkg::OP_BYTE, data: win_q[0], eos: (fill_q <= FW'(1))};
        win_d      = win_sh;
        if (fill_q <= FW'(1)) begin
          fill_d  = '0;
          flush_d = 1'b0;
        end else begin
          fill_d = fill_q - FW'(1);
        end
      end
    end else if (accept) begin
      if (hit) begin
        main_vld = (cfg_i.replacement_length != 5'd0);
        main_cmd = '{op: lsr_pkg::OP_REPL, data: 8'h00, eos: 1'b0};
        new_fill = '0;
        win_d    = app;
      end else if (do_cmp) begin
        main_vld = 1'b1;
        main_cmd = '{op: lsr_pkg::OP_BYTE, data: app[0], eos: 1'b0};
        new_fill = fill_q;
        win_d    = app_sh;
      end else begin
        new_fill = fill_q + FW'(1);
        win_d    = app;
      end
      fill_d = new_fill;

      if (last_byte_i) begin
        first_d = 1'b0;
        if (new_fill == '0) begin
          cmd_push_o = 1'b1;
          if (main_vld) begin
            cmd_o     = main_cmd;
            cmd_o.eos = 1'b1;
          end else begin
            cmd_o = '{op: lsr_pkg::OP_MARK, data: 8'h00, eos: 1'b1};
          end
        end else begin
          cmd_push_o = main_vld;
          cmd_o      = main_cmd;
          flush_d    = 1'b1;
        end
      end else begin
        cmd_push_o = main_vld;
        cmd_o      = main_cmd;
        if (hit) begin
          first_d = 1'b1;
        end
      end
    end

    if (cfg_i.clear_window) begin
      fill_d  = '0;
      flush_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      first_q <= 1'b0;
      flush_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      first_q <= first_d;
      flush_q <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  a_fill_below_plen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < plen)
    else $error("window holds a whole pattern between items");

  a_flush_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flush_q) |-> $past(last_byte_i && push))
    else $error("flush started without a final byte");

endmodule

>>> hdl/lsr_fifo.sv
// Short command queue that decouples the front and back parts.
// Depends on lsr_pkg for the command type and the queue depth.
module lsr_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  lsr_pkg::lsr_cmd_t  wdata_i,
  output logic               full_o,
  input  logic               rd_i,
  output lsr_pkg::lsr_cmd_t  rdata_o,
  output logic               valid_o
);

  localparam int Depth = lsr_pkg::FifoDepth;
  localparam int PW    = $clog2(Depth);

  lsr_pkg::lsr_cmd_t slot_q [Depth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   count_q;
  logic          do_wr, do_rd;

  assign full_o  = (count_q == (PW+1)'(Depth));
  assign valid_o = (count_q != '0);
  assign rdata_o = slot_q[rp_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= wp_q + PW'(1);
      end
      if (do_rd) begin
        rp_q <= rp_q + PW'(1);
      end
      count_q <= count_q + (PW+1)'(do_wr) - (PW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wp_q] <= wdata_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PW+1)'(Depth))
    else $error("command queue count overflow");

endmodule

>>> hdl/lsr_back.sv
// Back part: expands queued commands into output bytes behind an output register.
// Depends on lsr_pkg for the command and configuration types.
module lsr_back #(
  parameter int MAX_REPLACEMENT = lsr_pkg::MaxReplacementDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsr_pkg::lsr_cfg_t  cfg_i,
  input  lsr_pkg::lsr_cmd_t  cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_byte_o,
  output logic               byte_valid_o,
  output logic               end_of_string_o
);

  localparam int RW = $clog2(MAX_REPLACEMENT + 1);

  logic [RW-1:0] rlen;
  logic [RW-1:0] rep_idx_q, rep_idx_d;
  logic          out_vld_q;
  logic [7:0]    byte_q, nb;
  logic          bv_q, nv;
  logic          eos_q, ne;
  logic          adv, done, last_rep;

  always_comb begin
    if (int'(cfg_i.replacement_length) > MAX_REPLACEMENT) begin
      rlen = RW'(MAX_REPLACEMENT);
    end else begin
      rlen = RW'(cfg_i.replacement_length);
    end
  end

  assign adv      = cmd_valid_i && (!out_vld_q || pop);
  assign last_rep = ({1'b0, rep_idx_q} + (RW+1)'(1)) >= {1'b0, rlen};

  always_comb begin
    nb   = 8'h00;
    nv   = 1'b0;
    ne   = 1'b1;
    done = 1'b1;
    case (cmd_i.op)
      lsr_pkg::OP_BYTE: begin
        nb = cmd_i.data;
        nv = 1'b1;
        ne = cmd_i.eos;
      end
      lsr_pkg::OP_REPL: begin
        nb   = lsr_pkg::pick_byte(cfg_i.replacement, 32'(rep_idx_q));
        nv   = 1'b1;
        ne   = cmd_i.eos && last_rep;
        done = last_rep;
      end
      lsr_pkg::OP_MARK: begin
        nb = 8'h00;
        nv = 1'b0;
        ne = 1'b1;
      end
      default: begin
        nb = 8'h00;
        nv = 1'b0;
        ne = 1'b1;
      end
    endcase
  end

  assign cmd_pop_o = adv && done;

  always_comb begin
    rep_idx_d = rep_idx_q;
    if (adv) begin
      rep_idx_d = done ? '0 : rep_idx_q + RW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_idx_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      rep_idx_q <= rep_idx_d;
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (pop) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= nb;
      bv_q   <= nv;
      eos_q  <= ne;
    end
  end

  assign empty           = !out_vld_q;
  assign out_byte_o      = byte_q;
  assign byte_valid_o    = bv_q;
  assign end_of_string_o = eos_q;

  a_repl_in_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rep_idx_q != '0) |-> (cmd_valid_i && (cmd_i.op == lsr_pkg::OP_REPL)))
    else $error("replacement burst lost its command");

endmodule
